@@ hdl/lsla_pkg.sv @@
// Shared types, widths and codes for the lux with automatic gain unit.
`timescale 1ns / 1ps
`default_nettype none
package lsla_pkg;

    localparam int COUNT_W   = 16;
    localparam int LUX_W     = 32;
    localparam int FACTOR_W  = 32;
    localparam int STEP_W    = 3;
    localparam int MODE_W    = 3;
    localparam int GAIN_W    = 2;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 32;

    // time * gain is at most 600 * 9500, below 2^23
    localparam int TG_W   = 23;
    localparam int SQ_W   = 2 * COUNT_W;
    localparam int DEN_W  = COUNT_W + TG_W;
    localparam int NUM_W  = SQ_W + FACTOR_W;

    // factor is Q16.16, so the raw product carries 16 fraction bits
    localparam int PROD_FRAC_BITS        = 16;
    localparam int LUX_FRACTION_BITS_DEF = 8;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_INTEG_STEP = 2'd0,
        CFG_GAIN_MODE  = 2'd1,
        CFG_LUX_FACTOR = 2'd2
    } t_cfg_idx;

    typedef enum logic [GAIN_W-1:0] {
        GAIN_1X    = 2'd0,
        GAIN_25X   = 2'd1,
        GAIN_400X  = 2'd2,
        GAIN_9500X = 2'd3
    } t_gain;

    localparam logic [MODE_W-1:0] GAIN_MODE_AUTO = 3'd4;
    localparam logic [STEP_W-1:0] STEP_LAST      = 3'd5;

    localparam logic [STEP_W-1:0]   INTEG_STEP_RST = 3'd0;
    localparam logic [MODE_W-1:0]   GAIN_MODE_RST  = 3'd1;
    localparam logic [FACTOR_W-1:0] LUX_FACTOR_RST = 32'h0001_0000;

    typedef struct packed {
        logic [COUNT_W-1:0] full_count;
        logic [COUNT_W-1:0] ir_count;
    } t_in_word;

    typedef struct packed {
        logic [COUNT_W-1:0] full_reading;
        logic [COUNT_W-1:0] infrared_reading;
        logic [COUNT_W-1:0] visible_reading;
        logic [LUX_W-1:0]   lux_value;
        logic               overflow_flag;
        logic               zero_flag;
        logic [GAIN_W-1:0]  gain_used;
        logic               gain_changed;
        logic [GAIN_W-1:0]  next_gain;
    } t_out_word;

endpackage
`default_nettype wire

@@ hdl/lsla_mul.sv @@
// Bit-serial shift-add multiplier, one multiplier bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module lsla_mul #(
    parameter int AW = 16,
    parameter int BW = 16
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic [AW-1:0]     i_mcand,
    input  wire logic [BW-1:0]     i_mplier,
    output logic                   o_done,
    output logic [AW+BW-1:0]       o_product
);
    localparam int CW = (BW > 1) ? $clog2(BW) : 1;
    localparam logic [CW-1:0] LAST = CW'(BW - 1);

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [AW-1:0] r_mcand;
    logic [AW+BW-1:0] r_acc;
    logic [AW:0]   n_sum;

    // multiplier sits in the low bits and shifts out as the product shifts in
    assign n_sum = {1'b0, r_acc[AW+BW-1:BW]} + (r_acc[0] ? {1'b0, r_mcand} : {(AW+1){1'b0}});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_mcand <= i_mcand;
            r_acc   <= {{AW{1'b0}}, i_mplier};
        end else if (r_busy) begin
            r_acc <= {n_sum, r_acc[BW-1:1]};
        end
    end

    assign o_done    = r_done;
    assign o_product = r_acc;

endmodule
`default_nettype wire

@@ hdl/lsla_div.sv @@
// Restoring divider, one quotient bit per cycle, saturating quotient.
`timescale 1ns / 1ps
`default_nettype none
module lsla_div #(
    parameter int NW = 64,
    parameter int QW = 32,
    parameter int DW = 39
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire logic [NW-1:0] i_num,
    input  wire logic [DW-1:0] i_den,
    output logic               o_done,
    output logic [QW-1:0]      o_quot
);
    localparam int HW = NW - QW;
    localparam int MW = ((HW > DW) ? HW : DW) + 1;
    localparam int CW = (QW > 1) ? $clog2(QW) : 1;
    localparam logic [CW-1:0] LAST = CW'(QW - 1);

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [DW-1:0] r_rem;
    logic [DW-1:0] r_den;
    logic [QW-1:0] r_lo;

    logic [DW:0]   n_trial;
    logic [DW:0]   n_diff;
    logic          n_ge;
    logic          n_sat;

    // quotient needs more than QW bits when the upper numerator part reaches den
    assign n_sat   = MW'(i_num[NW-1:QW]) >= MW'(i_den);
    assign n_trial = {r_rem, r_lo[QW-1]};
    assign n_ge    = n_trial >= {1'b0, r_den};
    assign n_diff  = n_trial - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_cnt <= '0;
                if (n_sat) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_busy <= 1'b1;
                end
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // low numerator bits shift out at the top while quotient bits shift in
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_den <= i_den;
            r_rem <= DW'(i_num[NW-1:QW]);
            r_lo  <= n_sat ? {QW{1'b1}} : i_num[QW-1:0];
        end else if (r_busy) begin
            r_rem <= n_ge ? n_diff[DW-1:0] : n_trial[DW-1:0];
            r_lo  <= {r_lo[QW-2:0], n_ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_lo;

endmodule
`default_nettype wire

@@ hdl/light_sensor_lux_autogain_unit.sv @@
// Top level: lux with automatic gain for a two-channel light sensor.
//
// Takes one word of full-spectrum and infrared counts and returns one word with both
// counts, the visible count, lux in unsigned fixed point with LUX_FRACTION_BITS
// fraction bits (saturating), overflow and zero flags and the gain codes. One word is
// in work at a time. A word that needs lux passes from acceptance to the output register
// through d*d and full*time*gain (two bit-serial multipliers side by side), then the
// product with lux_factor, then the restoring divider; a saturating quotient skips the
// divider steps, and a word with overflow or a zero full count goes straight from
// acceptance to the done state and is loaded from there.
// A finished word waits in the output register while the next word is taken in.
// Configuration writes are always ready and must only be issued while the unit is idle.
`timescale 1ns / 1ps
`default_nettype none
module light_sensor_lux_autogain_unit #(
    parameter int LUX_FRACTION_BITS = lsla_pkg::LUX_FRACTION_BITS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire lsla_pkg::t_in_word            i_in_word,
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output lsla_pkg::t_out_word                o_out_word,
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [lsla_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [lsla_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import lsla_pkg::*;

    localparam int NUM_SHIFT = PROD_FRAC_BITS - LUX_FRACTION_BITS;

    localparam logic [9:0]  TIME_UNIT_MS = 10'd100;
    localparam logic [13:0] GAIN_X_LOW   = 14'd1;
    localparam logic [13:0] GAIN_X_MED   = 14'd25;
    localparam logic [13:0] GAIN_X_HIGH  = 14'd400;
    localparam logic [13:0] GAIN_X_MAX   = 14'd9500;

    localparam logic [COUNT_W-1:0] OVF_LIMIT_SHORT = 16'd36863;
    localparam logic [COUNT_W-1:0] OVF_LIMIT_LONG  = 16'hFFFF;
    localparam logic [COUNT_W-1:0] UPPER_SHORT     = 16'd31000;
    localparam logic [COUNT_W-1:0] UPPER_LONG      = 16'd62000;
    localparam logic [COUNT_W-1:0] LOW_TO_HIGH     = 16'd54;
    localparam logic [COUNT_W-1:0] LOW_TO_MED      = 16'd875;
    localparam logic [COUNT_W-1:0] MED_TO_MAX      = 16'd57;
    localparam logic [COUNT_W-1:0] MED_TO_HIGH     = 16'd1365;
    localparam logic [COUNT_W-1:0] HIGH_TO_MAX     = 16'd920;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_MUL1 = 5'b00010,
        ST_MUL2 = 5'b00100,
        ST_DIV  = 5'b01000,
        ST_DONE = 5'b10000
    } t_state;

    function automatic logic [TG_W-1:0] time_gain(input logic [STEP_W-1:0] step,
                                                  input t_gain g);
        logic [9:0]  ms;
        logic [13:0] gm;
        ms = (10'(step) + 10'd1) * TIME_UNIT_MS;
        case (g)
            GAIN_1X:    gm = GAIN_X_LOW;
            GAIN_25X:   gm = GAIN_X_MED;
            GAIN_400X:  gm = GAIN_X_HIGH;
            GAIN_9500X: gm = GAIN_X_MAX;
            default:    gm = GAIN_X_LOW;
        endcase
        return TG_W'({14'd0, ms} * {10'd0, gm});
    endfunction

    function automatic t_gain auto_next(input t_gain level, input logic [COUNT_W-1:0] full,
                                        input logic short_step);
        logic [COUNT_W-1:0] upper;
        t_gain              nxt;
        upper = short_step ? UPPER_SHORT : UPPER_LONG;
        nxt   = level;
        case (level)
            GAIN_1X: begin
                if (full < LOW_TO_HIGH)     nxt = GAIN_400X;
                else if (full < LOW_TO_MED) nxt = GAIN_25X;
            end
            GAIN_25X: begin
                if (full < MED_TO_MAX)       nxt = GAIN_9500X;
                else if (full < MED_TO_HIGH) nxt = GAIN_400X;
                else if (full > upper)       nxt = GAIN_1X;
            end
            GAIN_400X: begin
                if (full < HIGH_TO_MAX)  nxt = GAIN_9500X;
                else if (full > upper)   nxt = GAIN_1X;
            end
            GAIN_9500X: begin
                if (full > upper) nxt = GAIN_25X;
            end
            default: nxt = level;
        endcase
        return nxt;
    endfunction

    // configuration and gain state
    logic [STEP_W-1:0]   r_integ_step;
    logic [MODE_W-1:0]   r_gain_mode;
    logic [FACTOR_W-1:0] r_lux_factor;
    t_gain               r_auto_level;

    t_state              r_state;
    t_state              n_state;

    // word in work
    t_in_word            r_in;
    logic                r_ovf;
    logic                r_zero;
    t_gain               r_used;
    t_gain               r_next;
    logic                r_changed;
    logic [LUX_W-1:0]    r_lux;

    t_out_word           r_out;
    logic                r_out_valid;

    logic                in_accept;
    logic                out_free;
    logic [STEP_W-1:0]   eff_step;
    logic                short_step;
    logic                is_auto;
    t_gain               used;
    t_gain               next_lvl;
    logic                ovf;
    logic                zero;
    logic                skip;
    logic [COUNT_W-1:0]  diff_abs;

    logic                start_mul1;
    logic                start_mul2;
    logic                start_div;

    logic                sq_done;
    logic [SQ_W-1:0]     sq_p;
    logic                den_done;
    logic [DEN_W-1:0]    den_p;
    logic                num_done;
    logic [NUM_W-1:0]    num_p;
    logic [NUM_W-1:0]    num_sh;
    logic                div_done;
    logic [LUX_W-1:0]    div_q;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = (r_state != ST_IDLE);
    assign in_accept   = i_in_valid && !o_in_stall;
    assign out_free    = !r_out_valid || !i_out_stall;

    assign eff_step   = (r_integ_step > STEP_LAST) ? STEP_LAST : r_integ_step;
    assign short_step = (eff_step == INTEG_STEP_RST);
    assign is_auto    = (r_gain_mode >= GAIN_MODE_AUTO);
    assign used       = is_auto ? r_auto_level : t_gain'(r_gain_mode[GAIN_W-1:0]);
    assign next_lvl   = is_auto ? auto_next(used, i_in_word.full_count, short_step) : used;

    assign ovf = short_step
        ? (i_in_word.full_count == OVF_LIMIT_SHORT || i_in_word.ir_count == OVF_LIMIT_SHORT)
        : (i_in_word.full_count == OVF_LIMIT_LONG || i_in_word.ir_count == OVF_LIMIT_LONG);
    assign zero = (i_in_word.full_count == '0) && (i_in_word.ir_count == '0);
    assign skip = ovf || (i_in_word.full_count == '0);

    assign diff_abs = (i_in_word.full_count >= i_in_word.ir_count)
                    ? (i_in_word.full_count - i_in_word.ir_count)
                    : (i_in_word.ir_count - i_in_word.full_count);

    assign num_sh = num_p >> NUM_SHIFT;

    always_comb begin
        n_state    = r_state;
        start_mul1 = 1'b0;
        start_mul2 = 1'b0;
        start_div  = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (in_accept) begin
                    start_mul1 = !skip;
                    n_state    = skip ? ST_DONE : ST_MUL1;
                end
            end
            ST_MUL1: begin
                if (sq_done && den_done) begin
                    start_mul2 = 1'b1;
                    n_state    = ST_MUL2;
                end
            end
            ST_MUL2: begin
                if (num_done) begin
                    start_div = 1'b1;
                    n_state   = ST_DIV;
                end
            end
            ST_DIV: begin
                if (div_done) n_state = ST_DONE;
            end
            ST_DONE: begin
                if (out_free) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_out_valid  <= 1'b0;
            r_integ_step <= INTEG_STEP_RST;
            r_gain_mode  <= GAIN_MODE_RST;
            r_lux_factor <= LUX_FACTOR_RST;
            r_auto_level <= GAIN_25X;
        end else begin
            r_state <= n_state;
            if (r_state == ST_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (in_accept && is_auto) begin
                r_auto_level <= next_lvl;
            end
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_INTEG_STEP: r_integ_step <= i_cfg_data[STEP_W-1:0];
                    CFG_GAIN_MODE: begin
                        r_gain_mode <= i_cfg_data[MODE_W-1:0];
                        // fixed modes pin the level, automatic restarts at medium
                        r_auto_level <= (i_cfg_data[MODE_W-1:0] < GAIN_MODE_AUTO)
                                      ? t_gain'(i_cfg_data[GAIN_W-1:0]) : GAIN_25X;
                    end
                    CFG_LUX_FACTOR: r_lux_factor <= i_cfg_data[FACTOR_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in      <= i_in_word;
            r_ovf     <= ovf;
            r_zero    <= zero;
            r_used    <= used;
            r_next    <= next_lvl;
            r_changed <= (next_lvl != used);
            if (skip) r_lux <= '0;
        end
        if (r_state == ST_DIV && div_done) begin
            r_lux <= div_q;
        end
        if (r_state == ST_DONE && out_free) begin
            r_out.full_reading     <= r_in.full_count;
            r_out.infrared_reading <= r_in.ir_count;
            r_out.visible_reading  <= r_in.full_count - r_in.ir_count;
            r_out.lux_value        <= r_lux;
            r_out.overflow_flag    <= r_ovf;
            r_out.zero_flag        <= r_zero;
            r_out.gain_used        <= r_used;
            r_out.gain_changed     <= r_changed;
            r_out.next_gain        <= r_next;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

    // d*d
    lsla_mul #(
        .AW (COUNT_W),
        .BW (COUNT_W)
    ) u_mul_sq (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (start_mul1),
        .i_mcand   (diff_abs),
        .i_mplier  (diff_abs),
        .o_done    (sq_done),
        .o_product (sq_p)
    );

    // full * time * gain, finishes together with d*d
    lsla_mul #(
        .AW (TG_W),
        .BW (COUNT_W)
    ) u_mul_den (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (start_mul1),
        .i_mcand   (time_gain(eff_step, used)),
        .i_mplier  (i_in_word.full_count),
        .o_done    (den_done),
        .o_product (den_p)
    );

    // d*d * lux_factor
    lsla_mul #(
        .AW (FACTOR_W),
        .BW (SQ_W)
    ) u_mul_num (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (start_mul2),
        .i_mcand   (r_lux_factor),
        .i_mplier  (sq_p),
        .o_done    (num_done),
        .o_product (num_p)
    );

    lsla_div #(
        .NW (NUM_W),
        .QW (LUX_W),
        .DW (DEN_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start_div),
        .i_num   (num_sh),
        .i_den   (den_p),
        .o_done  (div_done),
        .o_quot  (div_q)
    );

endmodule
`default_nettype wire

@@ tb/sv/light_sensor_lux_autogain_unit_tb.sv @@
// Testbench for the lux with automatic gain unit: random and directed words, scoreboard check.
`timescale 1ns / 1ps
module light_sensor_lux_autogain_unit_tb;
    import lsla_pkg::*;

    localparam int CYCLE_LIMIT  = 2_500_000;
    localparam int MAX_REPORTS  = 40;
    localparam int RAND_PHASES  = 12;
    localparam int PHASE_WORDS  = 128;
    localparam int HOLD_CYCLES  = 600;
    localparam int END_PAUSE    = 120;
    localparam int LUX_SHIFT    = PROD_FRAC_BITS - LUX_FRACTION_BITS_DEF;

    localparam logic [COUNT_W-1:0] OVF_LIMIT_SHORT = 16'd36863;
    localparam logic [COUNT_W-1:0] OVF_LIMIT_LONG  = 16'hFFFF;
    localparam int UPPER_SHORT   = 31000;
    localparam int UPPER_LONG    = 62000;
    localparam int LOW_TO_HIGH   = 54;
    localparam int LOW_TO_MED    = 875;
    localparam int MED_TO_MAX    = 57;
    localparam int MED_TO_HIGH   = 1365;
    localparam int HIGH_TO_MAX   = 920;

    localparam longint unsigned GAIN_FACTOR [4] = '{64'd1, 64'd25, 64'd400, 64'd9500};
    localparam int EDGE_COUNTS [14] = '{53, 54, 56, 57, 874, 875, 919, 920,
                                        1364, 1365, 31000, 31001, 62000, 62001};

    class lux_scoreboard;
        logic [STEP_W-1:0]   integ_step;
        logic [MODE_W-1:0]   gain_mode;
        logic [FACTOR_W-1:0] lux_factor;
        t_gain               auto_level;
        t_out_word           due_readings[$];
        int mismatches, checked, accepted;
        int n_ovf, n_zero, n_sat, n_moves;

        function new();
            integ_step = INTEG_STEP_RST;
            gain_mode  = GAIN_MODE_RST;
            lux_factor = LUX_FACTOR_RST;
            auto_level = GAIN_25X;
        endfunction

        function void write_reg(t_cfg_idx idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_INTEG_STEP: integ_step = data[STEP_W-1:0];
                CFG_GAIN_MODE: begin
                    gain_mode  = data[MODE_W-1:0];
                    auto_level = (gain_mode < GAIN_MODE_AUTO) ? t_gain'(gain_mode[1:0])
                                                              : GAIN_25X;
                end
                CFG_LUX_FACTOR: lux_factor = data;
                default: ;
            endcase
        endfunction

        // predict the reading for an accepted word and advance the gain state
        function void note_counts(t_in_word w);
            logic [COUNT_W-1:0] full, ir, limit;
            logic [STEP_W-1:0]  step;
            bit                 is_auto;
            t_gain              used, nxt;
            longint unsigned    d, num, den, q;
            int                 upper;
            t_out_word          e;
            full = w.full_count;
            ir   = w.ir_count;
            step = (integ_step > STEP_LAST) ? STEP_LAST : integ_step;
            is_auto = gain_mode >= GAIN_MODE_AUTO;
            used  = is_auto ? auto_level : t_gain'(gain_mode[1:0]);
            limit = (step == 0) ? OVF_LIMIT_SHORT : OVF_LIMIT_LONG;
            e.full_reading     = full;
            e.infrared_reading = ir;
            e.visible_reading  = full - ir;
            e.overflow_flag    = (full == limit) || (ir == limit);
            e.zero_flag        = (full == 0) && (ir == 0);
            e.lux_value        = '0;
            if (!e.overflow_flag && full != 0) begin
                d   = (full >= ir) ? longint'(full) - longint'(ir) : longint'(ir) - longint'(full);
                num = d * d * longint'(lux_factor);
                den = longint'(full) * (longint'(step) + 1) * 100 * GAIN_FACTOR[used];
                q   = (num >> LUX_SHIFT) / den;
                if (q > 64'hFFFF_FFFF) begin
                    e.lux_value = '1;
                    n_sat++;
                end else begin
                    e.lux_value = q[LUX_W-1:0];
                end
            end
            nxt = used;
            if (is_auto) begin
                upper = (step == 0) ? UPPER_SHORT : UPPER_LONG;
                case (used)
                    GAIN_1X: begin
                        if (full < LOW_TO_HIGH) nxt = GAIN_400X;
                        else if (full < LOW_TO_MED) nxt = GAIN_25X;
                    end
                    GAIN_25X: begin
                        if (full < MED_TO_MAX) nxt = GAIN_9500X;
                        else if (full < MED_TO_HIGH) nxt = GAIN_400X;
                        else if (full > upper) nxt = GAIN_1X;
                    end
                    GAIN_400X: begin
                        if (full < HIGH_TO_MAX) nxt = GAIN_9500X;
                        else if (full > upper) nxt = GAIN_1X;
                    end
                    default: begin
                        if (full > upper) nxt = GAIN_25X;
                    end
                endcase
                auto_level = nxt;
            end
            e.gain_used    = used;
            e.gain_changed = (nxt != used);
            e.next_gain    = nxt;
            accepted++;
            n_ovf   += e.overflow_flag;
            n_zero  += e.zero_flag;
            n_moves += e.gain_changed;
            due_readings.push_back(e);
        endfunction

        function void compare_field(string field, logic [31:0] want, logic [31:0] got);
            if (got !== want) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
            end
        endfunction

        function void check_reading(t_out_word got);
            t_out_word want;
            if (due_readings.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: unexpected word, expected none, actual %h", $time, got);
                return;
            end
            want = due_readings.pop_front();
            checked++;
            compare_field("full_reading", 32'(want.full_reading), 32'(got.full_reading));
            compare_field("infrared_reading", 32'(want.infrared_reading),
                          32'(got.infrared_reading));
            compare_field("visible_reading", 32'(want.visible_reading),
                          32'(got.visible_reading));
            compare_field("lux_value", want.lux_value, got.lux_value);
            compare_field("overflow_flag", 32'(want.overflow_flag), 32'(got.overflow_flag));
            compare_field("zero_flag", 32'(want.zero_flag), 32'(got.zero_flag));
            compare_field("gain_used", 32'(want.gain_used), 32'(got.gain_used));
            compare_field("gain_changed", 32'(want.gain_changed), 32'(got.gain_changed));
            compare_field("next_gain", 32'(want.next_gain), 32'(got.next_gain));
        endfunction
    endclass

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    logic                  in_stall;
    t_in_word              in_word   = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    t_out_word             out_word;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    t_cfg_idx              cfg_index = CFG_INTEG_STEP;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    bit gaps_on  = 1'b1;
    bit stall_on = 1'b1;
    int hold_request = 0;
    int settings = 0;

    lux_scoreboard lux_board = new();

    light_sensor_lux_autogain_unit u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_word   (in_word),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_word  (out_word),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // mostly short, now and then long
    function automatic int pick_span();
        if ($urandom_range(0, 99) < 90) return $urandom_range(1, 4);
        return $urandom_range(10, 150);
    endfunction

    function automatic t_in_word pick_counts();
        t_in_word w;
        int unsigned sel;
        sel = $urandom_range(0, 99);
        w.full_count = COUNT_W'($urandom);
        w.ir_count   = COUNT_W'($urandom);
        if (sel < 30) begin
            w.ir_count = COUNT_W'($urandom_range(0, w.full_count));
        end else if (sel < 55) begin
            w.full_count = COUNT_W'(EDGE_COUNTS[$urandom_range(0, 13)]
                                    + int'($urandom_range(0, 4)) - 2);
            w.ir_count   = COUNT_W'($urandom_range(0, w.full_count));
        end else if (sel < 62) begin
            w.full_count = COUNT_W'($urandom_range(0, 3));
            w.ir_count   = COUNT_W'($urandom_range(0, 3));
        end else if (sel < 70) begin
            if ($urandom_range(0, 1)) w.full_count = $urandom_range(0, 1) ? OVF_LIMIT_SHORT
                                                                           : OVF_LIMIT_LONG;
            else w.ir_count = $urandom_range(0, 1) ? OVF_LIMIT_SHORT : OVF_LIMIT_LONG;
        end else if (sel < 75) begin
            w.full_count = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
        end
        return w;
    endfunction

    // hold valid across back-to-back words, drop it only for a gap
    task automatic send_counts(logic [COUNT_W-1:0] full, logic [COUNT_W-1:0] ir);
        int gap;
        gap = (gaps_on && $urandom_range(0, 99) < 45) ? pick_span() : 0;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_word  <= '{full_count: full, ir_count: ir};
        do @(posedge clk); while (in_stall);
        lux_board.note_counts('{full_count: full, ir_count: ir});
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [CFG_DATA_W-1:0] data);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        lux_board.write_reg(idx, data);
    endtask

    task automatic set_regs(logic [STEP_W-1:0] step, logic [MODE_W-1:0] mode,
                            logic [FACTOR_W-1:0] factor);
        write_reg(CFG_INTEG_STEP, CFG_DATA_W'(step));
        write_reg(CFG_GAIN_MODE, CFG_DATA_W'(mode));
        write_reg(CFG_LUX_FACTOR, factor);
        settings++;
    endtask

    // let every outstanding reading come back before touching registers
    task automatic drain(int pause);
        in_valid <= 1'b0;
        do @(posedge clk); while (lux_board.due_readings.size() != 0);
        repeat (pause) @(posedge clk);
    endtask

    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) lux_board.check_reading(out_word);
    end

    always begin : out_stall_gen
        int span;
        @(posedge clk);
        if (hold_request > 0) begin
            span = hold_request;
            hold_request = 0;
            out_stall <= 1'b1;
            for (int c = 0; c < span; c++) @(posedge clk);
            out_stall <= 1'b0;
        end else if (stall_on && $urandom_range(0, 99) < 10) begin
            span = pick_span();
            out_stall <= 1'b1;
            repeat (span) @(posedge clk);
            out_stall <= 1'b0;
        end
    end

    initial begin : watchdog
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("timeout after %0d cycles, %0d readings still due", CYCLE_LIMIT,
                 lux_board.due_readings.size());
        $display("status: fail");
        $finish;
    end

    initial begin : stimulus
        logic [STEP_W-1:0]   step;
        logic [MODE_W-1:0]   mode;
        logic [FACTOR_W-1:0] factor;
        t_in_word            w;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: step 0, medium gain, unity factor
        send_counts(16'd0, 16'd0);
        send_counts(16'd0, 16'd5);
        send_counts(OVF_LIMIT_SHORT, 16'd100);
        send_counts(16'd100, OVF_LIMIT_SHORT);
        send_counts(16'hFFFF, 16'd0);
        send_counts(16'd1000, 16'd2000);
        send_counts(16'hFFFF, 16'hFFFF);
        send_counts(16'd1, 16'd0);
        drain(4);

        // low gain, largest factor: quotient saturates
        set_regs(3'd0, {1'b0, GAIN_1X}, 32'hFFFF_FFFF);
        send_counts(16'hFFFF, 16'd0);
        send_counts(16'd36862, 16'd0);
        drain(4);

        // automatic gain walk at the long upper threshold, step 7 acts as step 5
        set_regs(3'd7, GAIN_MODE_AUTO, LUX_FACTOR_RST);
        send_counts(16'd56, 16'd0);
        send_counts(16'd62001, 16'd0);
        send_counts(16'd1364, 16'd0);
        send_counts(16'd919, 16'd0);
        send_counts(16'hFFFF, 16'd0);
        send_counts(16'd62001, 16'd3);
        send_counts(16'd53, 16'd0);
        send_counts(16'd62001, 16'd0);
        send_counts(16'd874, 16'd10);
        send_counts(16'd1365, 16'd1365);
        drain(4);

        // short upper threshold, mode 5 counts as automatic
        set_regs(3'd0, GAIN_MODE_AUTO + 3'd1, 32'd1);
        send_counts(16'd31001, 16'd0);
        send_counts(16'd875, 16'd0);
        send_counts(OVF_LIMIT_SHORT, OVF_LIMIT_SHORT);
        drain(4);

        set_regs(3'd6, GAIN_MODE_AUTO + 3'd2, 32'h0003_8000);
        send_counts(16'd40000, 16'd1000);
        drain(4);

        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            case (ph)
                0: begin step = 3'd0; mode = {1'b0, GAIN_400X}; factor = 32'd1; end
                1: begin
                    step = STEP_LAST; mode = {1'b0, GAIN_9500X}; factor = 32'hFFFF_FFFF;
                end
                default: begin
                    step = ($urandom_range(0, 99) < 75) ? STEP_W'($urandom_range(0, 5))
                                                        : STEP_W'($urandom_range(6, 7));
                    mode = $urandom_range(0, 1) ? MODE_W'($urandom_range(4, 7))
                                                : MODE_W'($urandom_range(0, 3));
                    case ($urandom_range(0, 3))
                        0: factor = LUX_FACTOR_RST;
                        1: factor = $urandom_range(1, 32'h0008_0000);
                        2: factor = 32'hFFFF_FFFF - $urandom_range(0, 3);
                        default: factor = $urandom | 32'd1;
                    endcase
                end
            endcase
            set_regs(step, mode, factor);
            gaps_on  = (ph != 3);
            stall_on = (ph != 3);
            if (ph == 2) begin
                gaps_on = 1'b0;
                hold_request = HOLD_CYCLES;
            end
            for (int i = 0; i < PHASE_WORDS; i++) begin
                w = pick_counts();
                send_counts(w.full_count, w.ir_count);
            end
            drain(4);
        end

        drain(END_PAUSE);
        $display("covered %0d words over %0d register settings, %0d readings checked",
                 lux_board.accepted, settings, lux_board.checked);
        $display("saw %0d overflow, %0d both-zero, %0d saturated lux, %0d automatic gain moves",
                 lux_board.n_ovf, lux_board.n_zero, lux_board.n_sat, lux_board.n_moves);
        if (lux_board.mismatches == 0 && lux_board.due_readings.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
